[rtl/core/wildcard_byte_pattern_scanner_macros.svh]
// Assertion helpers for the wildcard byte pattern scanner.
// All checks run on clk_i and are disabled while rst_ni is low.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication.
`define WBPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned PatBytes      = 16;
  localparam int unsigned PatIdxW       = $clog2(PatBytes);
  localparam int unsigned LenW          = 5;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned AdjW          = 32;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegBase    = 3'd0,
    RegPatLo   = 3'd1,
    RegPatHi   = 3'd2,
    RegWild    = 3'd3,
    RegLen     = 3'd4,
    RegAdjust  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       readable;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_item_t;

  // Register set as seen by the datapath; len is already clamped.
  typedef struct packed {
    logic [AddrW-1:0]             base;
    logic [PatBytes-1:0][7:0]     pat;
    logic [PatBytes-1:0]          wild;
    logic [LenW-1:0]              len;
    logic [AdjW-1:0]              adjust;
  } cfg_t;

endpackage

[rtl/core/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds a byte and its readable bit, passes them on to the
// next cell, and checks them against the pattern byte lined up with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_cell
  import wbps_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clr_i,
  input  logic [7:0] data_i,
  input  logic       valid_i,
  input  cfg_t       cfg_i,
  output logic [7:0] data_o,
  output logic       valid_o,
  output logic       hit_o
);

  logic [7:0]    data_q;
  logic          valid_q;
  logic          active;
  logic [PatIdxW-1:0] pidx;
  logic [7:0]    pbyte;
  logic          wild;

  // Cell 0 always takes the fresh byte; others take a blank after region end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i & ~(clr_i & (Idx != 0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  // Cell Idx (0 = newest) lines up with pattern byte len-1-Idx.
  assign active = LenW'(Idx) < cfg_i.len;
  assign pidx   = PatIdxW'(cfg_i.len - LenW'(1) - LenW'(Idx));
  assign pbyte  = cfg_i.pat[pidx];
  assign wild   = cfg_i.wild[pidx];

  assign hit_o   = ~active | (valid_q & (wild | (data_q == pbyte)));
  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

[rtl/core/wbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Configuration registers; pattern length is clamped as it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_cfg_regs
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t            cfg_q;
  cfg_t            cfg_d;
  logic [LenW-1:0] len_raw;
  logic [LenW-1:0] len_clamped;

  assign len_raw = cfg_wdata_i[LenW-1:0];

  always_comb begin
    if (len_raw == '0) begin
      len_clamped = LenW'(1);
    end else if (len_raw > LenW'(MaxPattern)) begin
      len_clamped = LenW'(MaxPattern);
    end else begin
      len_clamped = len_raw;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegBase:   cfg_d.base = cfg_wdata_i[AddrW-1:0];
        RegPatLo:  cfg_d.pat[7:0] = cfg_wdata_i[63:0];
        RegPatHi:  cfg_d.pat[15:8] = cfg_wdata_i[63:0];
        RegWild:   cfg_d.wild = cfg_wdata_i[PatBytes-1:0];
        RegLen:    cfg_d.len = len_clamped;
        RegAdjust: cfg_d.adjust = cfg_wdata_i[AdjW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base   <= '0;
      cfg_q.pat    <= '0;
      cfg_q.wild   <= '0;
      cfg_q.len    <= LenW'(1);
      cfg_q.adjust <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/wildcard_byte_pattern_scanner.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Finds the first window of a byte stream that matches a masked pattern.
// ----------------------------------------------------------------------------
// Takes one region byte per cycle with no gaps of its own while the output is
// not held. A byte shifts into a chain of window cells, each comparing its
// byte against the lined-up pattern byte; the AND of the cells decides the
// match and is registered with the start offset, then the base add and the
// low-word adjust take one register stage each. A result passes the window
// cells, then offset, address and output registers. A held output stops the
// whole pipeline and stalls the input with it. At most one result per region:
// the first match, or not found at the region-end byte. Registers may be
// written once no item is in flight, i.e. 3 unstalled cycles after the last
// item was accepted.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  cfg_t cfg;

  logic adv;
  logic acc;

  logic             restart_q;
  logic [AddrW-1:0] pos_q;

  logic             s1_valid_q;
  logic             s1_end_q;
  logic [AddrW-1:0] s1_pos_q;

  logic [7:0]            cell_data  [MaxPattern];
  logic                  cell_valid [MaxPattern];
  logic [MaxPattern-1:0] cell_hit;

  logic match;
  logic emit;
  logic done_q;

  logic             r2_valid_q;
  logic             r2_found_q;
  logic [AddrW-1:0] r2_off_q;
  logic [LenW-1:0]  len_m1;

  logic             r3_valid_q;
  logic             r3_found_q;
  logic [AddrW-1:0] r3_addr_q;

  logic      out_valid_q;
  out_item_t out_item_q;
  logic [AdjW-1:0] low_adj;

  wbps_cfg_regs #(
    .MaxPattern (MaxPattern)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Whole pipeline moves together; only a held output stops it.
  assign adv        = ~out_valid_q | ~out_stall_i;
  assign acc        = in_valid_i & adv;
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b0;
      pos_q     <= '0;
    end else if (acc) begin
      restart_q <= in_item_i.region_end;
      pos_q     <= in_item_i.region_end ? '0 : pos_q + AddrW'(1);
    end
  end

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    if (i == 0) begin : g_head
      wbps_cell #(
        .Idx (i)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc),
        .clr_i   (restart_q),
        .data_i  (in_item_i.data_byte),
        .valid_i (in_item_i.readable),
        .cfg_i   (cfg),
        .data_o  (cell_data[i]),
        .valid_o (cell_valid[i]),
        .hit_o   (cell_hit[i])
      );
    end else begin : g_body
      wbps_cell #(
        .Idx (i)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc),
        .clr_i   (restart_q),
        .data_i  (cell_data[i-1]),
        .valid_i (cell_valid[i-1]),
        .cfg_i   (cfg),
        .data_o  (cell_data[i]),
        .valid_o (cell_valid[i]),
        .hit_o   (cell_hit[i])
      );
    end
  end

  // Stage 1: item tags next to the window cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_end_q <= in_item_i.region_end;
      s1_pos_q <= pos_q;
    end
  end

  // Stage 2: match decision, first-match tracking, start offset.
  assign match  = &cell_hit;
  assign emit   = s1_valid_q & ~done_q & (match | s1_end_q);
  assign len_m1 = cfg.len - LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      r2_valid_q <= 1'b0;
      r3_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (s1_valid_q) begin
        done_q <= s1_end_q ? 1'b0 : (done_q | match);
      end
      r2_valid_q  <= emit;
      r3_valid_q  <= r2_valid_q;
      out_valid_q <= r3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_found_q <= match;
      r2_off_q   <= s1_pos_q - {{(AddrW-LenW){1'b0}}, len_m1};
      // Stage 3: absolute address.
      r3_found_q <= r2_found_q;
      r3_addr_q  <= cfg.base + r2_off_q;
      // Stage 4: low-word adjust.
      out_item_q.found         <= r3_found_q;
      out_item_q.match_address <= r3_found_q ? {r3_addr_q[AddrW-1:AdjW], low_adj} : '0;
    end
  end

  assign low_adj = r3_addr_q[AdjW-1:0] + cfg.adjust;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`include "wildcard_byte_pattern_scanner_macros.svh"

  `WBPS_ASSERT_NEXT(a_done_after_hit, adv && s1_valid_q && match && !s1_end_q, done_q, "hit lost")
  `WBPS_ASSERT_NEXT(a_done_clr_at_end, adv && s1_valid_q && s1_end_q, !done_q, "hit kept past end")
  `WBPS_ASSERT(a_stall_only_when_full, in_stall_o, out_valid_o, "input stalled with empty output")
  `WBPS_ASSERT(a_not_found_zero, out_valid_o && !out_item_o.found, out_item_o.match_address == '0, "not-found item carries an address")

endmodule
